// ===== rtl/core/mgs_pkg.sv =====
`default_nettype none

package mgs_pkg;

    // Shared multiplier operand width: covers 2u-1 scaled (17b signed),
    // step size (16b unsigned) and position (16b signed)
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    // Exp table entry width, entry 0 is 65536
    localparam int ROM_W = 17;

    localparam logic [15:0] STEP_SIZE_RESET = 16'd4096;

    localparam logic [63:0] Q56_ONE = 64'd1 << 56;

    // Entries from this block of 32 on are zero
    localparam int ROM_ZERO_BLOCK = 14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIAL,
        ST_SQUARE,
        ST_DIFF,
        ST_LOOKUP,
        ST_DECIDE
    } t_state;

    // floor(a*b / 2^56) from 32-bit partial products, wrapping at 64 bits
    function automatic logic [63:0] mul_q56(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0;
        logic [63:0] a1;
        logic [63:0] b0;
        logic [63:0] b1;
        logic [63:0] mid;
        logic [63:0] low;
        a0  = {32'd0, a[31:0]};
        a1  = {32'd0, a[63:32]};
        b0  = {32'd0, b[31:0]};
        b1  = {32'd0, b[63:32]};
        low = a0 * b0;
        mid = a0 * b1 + a1 * b0 + (low >> 32);
        return ((a1 * b1) << 8) + (mid >> 24);
    endfunction

    // Unsigned floor quotient, restoring shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-j/32) in Q56, alternating Taylor series, j in 0..32
    function automatic logic [63:0] exp_neg_frac(input logic [5:0] j);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q56_ONE;
        sum  = Q56_ONE;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                // floor(term*j / (32*n)): drop the 32 first, then divide by n
                term = udiv64((term * {58'd0, j}) >> 5, 64'(n));
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // round(65536 * exp(-k/32)), evaluated at elaboration only
    function automatic logic [ROM_W-1:0] exp_rom_entry(input int k);
        int          q;
        logic [63:0] e1;
        logic [63:0] v;
        logic [63:0] rnd;
        q  = k >> 5;
        e1 = exp_neg_frac(6'd32);
        v  = exp_neg_frac(6'(k & 31));
        for (int i = 0; i < ROM_ZERO_BLOCK; i++) begin
            if (i < q) begin
                v = mul_q56(v, e1);
            end
        end
        rnd = (v + (64'd1 << 39)) >> 40;
        if (q >= ROM_ZERO_BLOCK) begin
            return '0;
        end
        return rnd[ROM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mgs_mul.sv =====
`default_nettype none

module mgs_mul
    import mgs_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [MUL_W-1:0]  i_a,
    input  wire logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]      o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Single signed multiply, product registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/mgs_rom.sv =====
`default_nettype none

module mgs_rom
    import mgs_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [ROM_W-1:0]                o_data
);

    typedef logic [DEPTH-1:0][ROM_W-1:0] t_rom_table;

    function automatic t_rom_table build_table();
        t_rom_table tab;
        for (int k = 0; k < int'(DEPTH); k++) begin
            tab[k] = exp_rom_entry(k);
        end
        return tab;
    endfunction

    localparam t_rom_table ROM_TABLE = build_table();

    logic [ROM_W-1:0] r_data;

    // Registered read
    always_ff @(posedge i_clk) begin
        r_data <= ROM_TABLE[i_addr];
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/metropolis_gaussian_step.sv =====
// One step of a 1-D Metropolis walker over a standard Gaussian.
// Input channel: i_in_valid / o_in_stall carry one word of two 16-bit
// uniforms; a word is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry the new position, the
// accept flag, the position squared and the running accept count.
// Config: i_cfg_we writes i_cfg_wdata into the step size (Q4.12 half-width);
// write only while the block is idle.
// Sequence: idle, trial, square, diff, lookup, decide; the result is loaded
// on leaving decide, and only then does the block return to idle to take a new word.
// The sequencer runs the one shared 17x17 multiplier twice (offset, trial
// square) plus one registered exp table read.
// The old position square is kept in a register, not recomputed.
// A stalled result stays in the output register; the block can finish the
// next word up to the decision and waits there until the slot frees.
// Reset (synchronous, active low): position, square and count go to zero,
// step size to 1.0, no result pending, input ready.
`default_nettype none

module metropolis_gaussian_step
    import mgs_pkg::*;
#(
    parameter int unsigned EXP_TABLE_DEPTH        = 256,
    parameter int unsigned POSITION_FRACTION_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [15:0]        i_uniform_step,
    input  wire logic [15:0]        i_uniform_accept,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_new_position,
    output logic                    o_accepted,
    output logic [31:0]             o_squared_value,
    output logic [31:0]             o_accept_total
);

    localparam int ROM_AW  = $clog2(EXP_TABLE_DEPTH);
    localparam int K_SHIFT = 2 * int'(POSITION_FRACTION_BITS) - 4;

    t_state r_state;
    t_state n_state;

    logic [15:0]         r_step;
    logic [15:0]         r_ua;
    logic signed [15:0]  r_x;
    logic [31:0]         r_x2;
    logic [31:0]         r_count;
    logic signed [15:0]  r_trial;
    logic [31:0]         r_t2;
    logic                r_uphill;
    logic                r_in_range;
    logic [ROM_AW-1:0]   r_addr;

    logic signed [15:0]  r_out_pos;
    logic                r_out_acc;
    logic [31:0]         r_out_sq;
    logic [31:0]         r_out_total;
    logic                r_out_valid;

    logic                    mul_en;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ROM_W-1:0]        rom_data;
    logic                    out_load;

    // Shared multiplier and exp table
    mgs_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mgs_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_addr),
        .o_data (rom_data)
    );

    // Proposal operands: 2u - 65536 as 17-bit signed, step size zero-extended
    logic signed [MUL_W-1:0] prop_s;
    logic signed [MUL_W-1:0] step_ext;
    logic signed [MUL_W-1:0] trial_ext;
    assign prop_s    = $signed({i_uniform_step, 1'b0} - 17'h10000);
    assign step_ext  = $signed({1'b0, r_step});
    assign trial_ext = {r_trial[15], r_trial};

    // Trial position: floor shift of the product, add, saturate
    logic signed [16:0] offset;
    logic signed [17:0] trial_sum;
    logic signed [15:0] trial_sat;
    assign offset    = prod[32:16];
    assign trial_sum = {{2{r_x[15]}}, r_x} + {offset[16], offset};
    always_comb begin
        if (trial_sum[17:15] == 3'b000 || trial_sum[17:15] == 3'b111) begin
            trial_sat = trial_sum[15:0];
        end else if (trial_sum[17]) begin
            trial_sat = 16'sh8000;
        end else begin
            trial_sat = 16'sh7FFF;
        end
    end

    // Energy rise and table index
    logic [31:0] t2;
    logic [31:0] diff;
    logic [31:0] k_idx;
    assign t2    = prod[31:0];
    assign diff  = t2 - r_x2;
    assign k_idx = diff >> K_SHIFT;

    // Decision and saturating count
    logic        acc;
    logic [31:0] n_count;
    assign acc     = r_uphill || (r_in_range && ({1'b0, r_ua} < rom_data));
    assign n_count = (acc && r_count != 32'hFFFF_FFFF) ? r_count + 32'd1 : r_count;

    // Sequencer: next state and unit controls
    always_comb begin
        n_state  = r_state;
        mul_en   = 1'b0;
        mul_a    = prop_s;
        mul_b    = step_ext;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    mul_en  = 1'b1;
                    n_state = ST_TRIAL;
                end
            end
            ST_TRIAL: begin
                n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                mul_en  = 1'b1;
                mul_a   = trial_ext;
                mul_b   = trial_ext;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_SIZE_RESET;
            r_x         <= '0;
            r_x2        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (out_load) begin
                if (acc) begin
                    r_x  <= r_trial;
                    r_x2 <= r_t2;
                end
                r_count <= n_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-word payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_ua <= i_uniform_accept;
        end
        if (r_state == ST_TRIAL) begin
            r_trial <= trial_sat;
        end
        if (r_state == ST_DIFF) begin
            r_t2       <= t2;
            r_uphill   <= (t2 <= r_x2);
            r_in_range <= (k_idx < 32'(EXP_TABLE_DEPTH));
            r_addr     <= k_idx[ROM_AW-1:0];
        end
        if (out_load) begin
            r_out_pos   <= acc ? r_trial : r_x;
            r_out_acc   <= acc;
            r_out_sq    <= acc ? r_t2 : r_x2;
            r_out_total <= n_count;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_new_position  = r_out_pos;
    assign o_accepted      = r_out_acc;
    assign o_squared_value = r_out_sq;
    assign o_accept_total  = r_out_total;

endmodule

`default_nettype wire
